/* rtl/gio_pkg.sv */
// Shared types, codes and constant tables for the gear indicator overlay.
// No dependencies; imported by every module of the block.
package gio_pkg;

  typedef enum logic [1:0] {
    ACT_BUTTON = 2'd0,
    ACT_PIXEL  = 2'd1,
    ACT_FRAME  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_CORNER   = 3'd1,
    REG_COLOR    = 3'd2,
    REG_ALPHA    = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_VERTICAL = 3'd6,
    REG_FLIPPED  = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    CODE_CLEAR = 2'd0,
    CODE_COLOR = 2'd1,
    CODE_BLACK = 2'd2,
    CODE_GREY  = 2'd3
  } glyph_code_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        shift_button;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] background;
  } in_t;

  typedef struct packed {
    logic [23:0] pixel_out;
    logic        gear_high;
  } out_t;

  typedef struct packed {
    logic        overlay_enable;
    logic [1:0]  corner;
    logic [23:0] overlay_color;
    logic [7:0]  blend_alpha;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic        vertical;
    logic        flipped;
  } cfg_t;

  localparam int          GLYPH_SIZE  = 8;
  localparam logic [23:0] GREY_COLOR  = 24'h1f1f1f;
  localparam logic [7:0]  GREY_ALPHA  = 8'((255 * 20) / 100);
  localparam logic [4:0]  FLASH_START = 5'd19;

  localparam logic [1:0] GLYPH_LOW [64] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  localparam logic [1:0] GLYPH_HIGH [64] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0,
    2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2,
    2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  // Entry 1 is replaced by the configured color.
  localparam logic [23:0] FLASH_TABLE [16] = '{
    24'h000000, 24'h000000, 24'h42f4f4, 24'hffffff,
    24'h0000ff, 24'h9200f4, 24'hf4f400, 24'hf45900,
    24'h00d8f4, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

endpackage

/* rtl/gio_draw.sv */
// Box placement, glyph lookup and per-channel alpha blend for one pixel.
// Depends on gio_pkg for the config type, glyph ROMs and flash colors.
module gio_draw
  import gio_pkg::*;
(
  input  cfg_t        cfg,
  input  logic        gear,
  input  logic [4:0]  timer,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [23:0] background,
  output logic        box_fits,
  output logic [23:0] pixel_out
);

  function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] b,
                                     input logic [7:0] a);
    logic [8:0]  a2;
    logic [16:0] sum;
    begin
      a2  = 9'd256 - {1'b0, a};
      sum = {9'd0, c} * {9'd0, a} + {9'd0, b} * {8'd0, a2};
      mix = sum[15:8];
    end
  endfunction

  logic signed [14:0] w_s, h_s, bx, by, dx, dy;
  logic [1:0]         pos;
  logic               in_box;
  logic [2:0]         ox, oy;
  logic [5:0]         idx;
  logic [1:0]         code;
  logic [3:0]         k;
  logic [23:0]        col;
  logic [7:0]         a;

  assign w_s = signed'({2'b00, cfg.screen_width});
  assign h_s = signed'({2'b00, cfg.screen_height});
  assign pos = cfg.corner ^ {cfg.flipped, cfg.flipped};

  always_comb begin
    if (cfg.vertical) begin
      unique case (pos)
        2'd0: begin bx = w_s - 15'sd9; by = 15'sd1; end
        2'd1: begin bx = w_s - 15'sd9; by = h_s - 15'sd10; end
        2'd2: begin bx = 15'sd1;       by = 15'sd1; end
        default: begin bx = 15'sd1;    by = h_s - 15'sd10; end
      endcase
    end else begin
      unique case (pos)
        2'd0: begin bx = 15'sd1;        by = 15'sd1; end
        2'd1: begin bx = w_s - 15'sd10; by = 15'sd1; end
        2'd2: begin bx = 15'sd1;        by = h_s - 15'sd9; end
        default: begin bx = w_s - 15'sd10; by = h_s - 15'sd9; end
      endcase
    end
  end

  assign box_fits = (bx >= 15'sd0) && (bx <= w_s - 15'(GLYPH_SIZE));

  assign dx     = signed'({3'b000, pixel_x}) - bx;
  assign dy     = signed'({3'b000, pixel_y}) - by;
  assign in_box = (dx[14:3] == 12'd0) && (dy[14:3] == 12'd0);
  assign ox     = dx[2:0];
  assign oy     = dy[2:0];

  always_comb begin
    unique case ({cfg.flipped, cfg.vertical})
      2'b00:   idx = {oy, ox};
      2'b01:   idx = {ox, oy};
      2'b10:   idx = {oy, ~ox};
      default: idx = {ox, ~oy};
    endcase
  end

  assign code = gear ? GLYPH_HIGH[idx] : GLYPH_LOW[idx];
  assign k    = timer[4:1];

  always_comb begin
    a = cfg.blend_alpha;
    if (timer == 5'd0 || k == 4'd1) begin
      col = cfg.overlay_color;
    end else begin
      col = FLASH_TABLE[k];
    end
    case (code)
      CODE_BLACK: col = 24'h000000;
      CODE_GREY: begin
        col = GREY_COLOR;
        a   = GREY_ALPHA;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!cfg.overlay_enable || !box_fits || !in_box || code == CODE_CLEAR) begin
      pixel_out = background;
    end else begin
      pixel_out = {mix(col[23:16], background[23:16], a),
                   mix(col[15:8],  background[15:8],  a),
                   mix(col[7:0],   background[7:0],   a)};
    end
  end

endmodule

/* rtl/gear_indicator_overlay_blend_unit.sv */
// Gear indicator overlay. Throughput one item per cycle unless the output stalls;
// input register, then gear/timer update and blend in one pass into the result
// register, which holds under back-pressure. Synchronous reset clears handshakes,
// gear, button and timer state and loads the register defaults. Config writes are
// taken every cycle. Uses gio_draw.
module gear_indicator_overlay_blend_unit
  import gio_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t        cfg;
  in_t         stage;
  logic        stage_valid;
  logic        gear, gear_next;
  logic        prev_button, prev_button_next;
  logic [4:0]  timer, timer_next;
  logic        out_free, advance, box_fits;
  logic [23:0] pixel_out;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = stage_valid && out_free;
  assign in_ready  = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overlay_enable <= 1'b1;
      cfg.corner         <= 2'd3;
      cfg.overlay_color  <= 24'h00ff00;
      cfg.blend_alpha    <= 8'd204;
      cfg.screen_width   <= 13'd320;
      cfg.screen_height  <= 13'd240;
      cfg.vertical       <= 1'b0;
      cfg.flipped        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLE:   cfg.overlay_enable <= cfg_data[0];
        REG_CORNER:   cfg.corner         <= cfg_data[1:0];
        REG_COLOR:    cfg.overlay_color  <= cfg_data;
        REG_ALPHA:    cfg.blend_alpha    <= cfg_data[7:0];
        REG_WIDTH:    cfg.screen_width   <= cfg_data[12:0];
        REG_HEIGHT:   cfg.screen_height  <= cfg_data[12:0];
        REG_VERTICAL: cfg.vertical       <= cfg_data[0];
        default:      cfg.flipped        <= cfg_data[0];
      endcase
    end
  end

  gio_draw u_draw (
    .cfg        (cfg),
    .gear       (gear),
    .timer      (timer),
    .pixel_x    (stage.pixel_x),
    .pixel_y    (stage.pixel_y),
    .background (stage.background),
    .box_fits   (box_fits),
    .pixel_out  (pixel_out)
  );

  always_comb begin
    gear_next        = gear;
    prev_button_next = prev_button;
    timer_next       = timer;
    case (action_t'(stage.action))
      ACT_BUTTON: begin
        if (stage.shift_button && !prev_button) begin
          gear_next  = !gear;
          timer_next = FLASH_START;
        end
        prev_button_next = stage.shift_button;
      end
      ACT_FRAME: begin
        if (cfg.overlay_enable && box_fits && timer != 5'd0) begin
          timer_next = timer - 5'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      gear        <= 1'b0;
      prev_button <= 1'b0;
      timer       <= 5'd0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
      if (advance) begin
        gear        <= gear_next;
        prev_button <= prev_button_next;
        timer       <= timer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= in_data;
    end
    if (advance) begin
      out_data.pixel_out <= (action_t'(stage.action) == ACT_PIXEL) ? pixel_out
                                                                   : stage.background;
      out_data.gear_high <= gear_next;
    end
  end

endmodule

/* test/tb_gear_indicator_overlay_blend_unit.sv */
// Testbench for gear_indicator_overlay_blend_unit: predicts gear, flash timer and
// blended pixels for every accepted item and checks each result in order.
// Depends on gio_pkg and the gear_indicator_overlay_blend_unit RTL.
`timescale 1ns / 1ps

module tb_gear_indicator_overlay_blend_unit;
  import gio_pkg::*;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  typedef enum int {
    FLOW_FREE       = 0,
    FLOW_SEND_IDLE  = 1,
    FLOW_RECV_STALL = 2,
    FLOW_BOTH_IDLE  = 3
  } flow_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  cfg_t        settings;
  logic        gear_flag;
  logic        prev_button;
  logic [4:0]  flash_timer;

  out_t        expected_pixels[$];
  out_t        oldest_pixel;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic        hold_request = 1'b0;

  gear_indicator_overlay_blend_unit u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void box_origin(output int bx, output int by);
    int w, h;
    logic [1:0] pos;
    w = int'(settings.screen_width);
    h = int'(settings.screen_height);
    pos = settings.corner ^ (settings.flipped ? 2'b11 : 2'b00);
    if (settings.vertical) begin
      case (corner_t'(pos))
        CORNER_TL: begin bx = w - 1 - GLYPH_SIZE; by = 1; end
        CORNER_BR: begin bx = 1; by = h - 2 - GLYPH_SIZE; end
        CORNER_BL: begin bx = 1; by = 1; end
        default:   begin bx = w - 1 - GLYPH_SIZE; by = h - 2 - GLYPH_SIZE; end
      endcase
    end else begin
      case (corner_t'(pos))
        CORNER_BL: begin bx = 1; by = h - 1 - GLYPH_SIZE; end
        CORNER_TR: begin bx = w - 2 - GLYPH_SIZE; by = 1; end
        CORNER_TL: begin bx = 1; by = 1; end
        default:   begin bx = w - 2 - GLYPH_SIZE; by = h - 1 - GLYPH_SIZE; end
      endcase
    end
  endfunction

  function automatic bit box_fits(input int bx);
    return !(bx < 0 || bx > int'(settings.screen_width) - GLYPH_SIZE);
  endfunction

  function automatic logic [23:0] mix_rgb(input logic [23:0] bg, input logic [23:0] col,
                                          input logic [7:0] a);
    logic [23:0] res;
    int sum;
    for (int ch = 0; ch < 3; ch++) begin
      sum = int'(col[ch*8 +: 8]) * int'(a) + int'(bg[ch*8 +: 8]) * (256 - int'(a));
      res[ch*8 +: 8] = 8'(sum >> 8);
    end
    return res;
  endfunction

  function automatic logic [23:0] overlay_pixel(input logic [11:0] px, input logic [11:0] py,
                                                input logic [23:0] bg);
    int bx, by, dx, dy, idx;
    logic [1:0] code;
    logic [3:0] k;
    logic [23:0] col;
    if (!settings.overlay_enable) return bg;
    box_origin(bx, by);
    if (!box_fits(bx)) return bg;
    dx = int'(px) - bx;
    dy = int'(py) - by;
    if (dx < 0 || dx >= GLYPH_SIZE || dy < 0 || dy >= GLYPH_SIZE) return bg;
    if (settings.flipped) idx = settings.vertical ? dx * 8 + (7 - dy) : dy * 8 + (7 - dx);
    else idx = settings.vertical ? dx * 8 + dy : dy * 8 + dx;
    code = gear_flag ? GLYPH_HIGH[idx] : GLYPH_LOW[idx];
    case (glyph_code_t'(code))
      CODE_CLEAR: return bg;
      CODE_GREY: return mix_rgb(bg, GREY_COLOR, GREY_ALPHA);
      CODE_BLACK: col = 24'h000000;
      default: begin
        k = flash_timer[4:1];
        col = (flash_timer == 0 || k == 1) ? settings.overlay_color : FLASH_TABLE[k];
      end
    endcase
    return mix_rgb(bg, col, settings.blend_alpha);
  endfunction

  function automatic out_t overlay_result(input in_t item);
    out_t res;
    int bx, by;
    res.pixel_out = item.background;
    case (action_t'(item.action))
      ACT_BUTTON: begin
        if (item.shift_button && !prev_button) begin
          gear_flag = ~gear_flag;
          flash_timer = FLASH_START;
        end
        prev_button = item.shift_button;
      end
      ACT_PIXEL: res.pixel_out = overlay_pixel(item.pixel_x, item.pixel_y, item.background);
      ACT_FRAME: begin
        box_origin(bx, by);
        if (settings.overlay_enable && box_fits(bx) && flash_timer != 0)
          flash_timer = flash_timer - 5'd1;
      end
      default: ;
    endcase
    res.gear_high = gear_flag;
    return res;
  endfunction

  function automatic in_t make_item(input action_t a, input logic btn, input int x, input int y,
                                    input logic [23:0] bg);
    in_t item;
    item.action = a;
    item.shift_button = btn;
    item.pixel_x = 12'(x);
    item.pixel_y = 12'(y);
    item.background = bg;
    return item;
  endfunction

  function automatic in_t random_item();
    in_t item;
    int bx, by;
    int unsigned pick;
    pick = $urandom_range(99);
    item.shift_button = 1'($urandom_range(1));
    item.pixel_x = 12'($urandom);
    item.pixel_y = 12'($urandom);
    case ($urandom_range(7))
      0: item.background = 24'h000000;
      1: item.background = 24'hffffff;
      default: item.background = 24'($urandom);
    endcase
    if (pick < 6) item.action = ACT_BUTTON;
    else if (pick < 30) item.action = ACT_FRAME;
    else if (pick < 33) item.action = ACT_NONE;
    else begin
      item.action = ACT_PIXEL;
      if (pick < 85) begin
        box_origin(bx, by);
        item.pixel_x = 12'(bx - 1 + int'($urandom_range(9)));
        item.pixel_y = 12'(by - 1 + int'($urandom_range(9)));
      end
    end
    return item;
  endfunction

  function automatic cfg_t settings_of(input logic en, input corner_t c, input logic [23:0] color,
                                       input logic [7:0] alpha, input logic [12:0] w,
                                       input logic [12:0] h, input logic v, input logic f);
    cfg_t s;
    s.overlay_enable = en;
    s.corner = c;
    s.overlay_color = color;
    s.blend_alpha = alpha;
    s.screen_width = w;
    s.screen_height = h;
    s.vertical = v;
    s.flipped = f;
    return s;
  endfunction

  function automatic cfg_t random_settings();
    return settings_of(1'($urandom_range(7) != 0), corner_t'($urandom_range(3)), 24'($urandom),
                       8'($urandom), 13'($urandom_range(4096, 16)), 13'($urandom_range(4096, 16)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] want,
                                 input logic [23:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch %0d on %s: expected %h, got %h", mismatch_count, what, want, got);
  endtask

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_FREE: begin send_idle_pct = 0; stall_pct <= 0; end
      FLOW_SEND_IDLE: begin send_idle_pct = 79; stall_pct <= 0; end
      FLOW_RECV_STALL: begin send_idle_pct = 0; stall_pct <= 79; end
      default: begin send_idle_pct = 17; stall_pct <= 17; end
    endcase
  endtask

  task automatic send_item(input in_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(overlay_result(item));
  endtask

  task automatic load_settings(input cfg_t s);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int r = 0; r < 8; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(r);
      case (reg_index_t'(r))
        REG_ENABLE:   cfg_data <= 24'(s.overlay_enable);
        REG_CORNER:   cfg_data <= 24'(s.corner);
        REG_COLOR:    cfg_data <= s.overlay_color;
        REG_ALPHA:    cfg_data <= 24'(s.blend_alpha);
        REG_WIDTH:    cfg_data <= 24'(s.screen_width);
        REG_HEIGHT:   cfg_data <= 24'(s.screen_height);
        REG_VERTICAL: cfg_data <= 24'(s.vertical);
        default:      cfg_data <= 24'(s.flipped);
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings = s;
  endtask

  // Default placement puts the box at (310,231).
  task automatic test_directed();
    set_flow(FLOW_FREE);
    send_item(make_item(ACT_FRAME, 1'b0, 0, 0, 24'h000000));
    send_item(make_item(ACT_PIXEL, 1'b0, 310, 231, 24'hffffff));
    send_item(make_item(ACT_PIXEL, 1'b1, 312, 232, 24'h000000));
    send_item(make_item(ACT_PIXEL, 1'b0, 314, 233, 24'hffffff));
    send_item(make_item(ACT_PIXEL, 1'b0, 309, 231, 24'h00ff00));
    send_item(make_item(ACT_PIXEL, 1'b0, 318, 238, 24'h0000ff));
    send_item(make_item(ACT_PIXEL, 1'b0, 317, 238, 24'hff0000));
    send_item(make_item(ACT_NONE, 1'b1, 312, 232, 24'h123456));
    send_item(make_item(ACT_BUTTON, 1'b1, 0, 0, 24'hfedcba));
    send_item(make_item(ACT_BUTTON, 1'b1, 4095, 4095, 24'h000000));
    send_item(make_item(ACT_PIXEL, 1'b0, 311, 232, 24'hffffff));
    send_item(make_item(ACT_FRAME, 1'b1, 4095, 0, 24'hffffff));
    send_item(make_item(ACT_PIXEL, 1'b0, 311, 232, 24'h000000));
    send_item(make_item(ACT_BUTTON, 1'b0, 0, 4095, 24'h000000));
    send_item(make_item(ACT_BUTTON, 1'b1, 0, 0, 24'h000000));
    send_item(make_item(ACT_PIXEL, 1'b1, 4095, 4095, 24'hffffff));
    send_item(make_item(ACT_PIXEL, 1'b0, 0, 0, 24'h000000));
    send_item(make_item(ACT_PIXEL, 1'b0, 312, 236, 24'ha5a5a5));
  endtask

  task automatic test_glyph_orientation();
    cfg_t s;
    int bx, by;
    for (int o = 0; o < 4; o++) begin
      s = settings_of(1'b1, corner_t'($urandom_range(3)), 24'($urandom), 8'($urandom),
                      13'($urandom_range(4096, 16)), 13'($urandom_range(4096, 16)),
                      o[1], o[0]);
      load_settings(s);
      set_flow(flow_t'(o));
      box_origin(bx, by);
      for (int g = 0; g < 2; g++) begin
        send_item(make_item(ACT_BUTTON, 1'b0, 0, 0, 24'($urandom)));
        send_item(make_item(ACT_BUTTON, 1'b1, 0, 0, 24'($urandom)));
        for (int y = 0; y < GLYPH_SIZE; y++) begin
          for (int x = 0; x < GLYPH_SIZE; x++)
            send_item(make_item(ACT_PIXEL, 1'b0, bx + x, by + y, 24'($urandom)));
          send_item(make_item(ACT_FRAME, 1'b0, 0, 0, 24'($urandom)));
        end
      end
    end
  endtask

  task automatic test_random_settings();
    cfg_t s;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: s = settings_of(1'b1, CORNER_TL, 24'h000000, 8'd0, 13'd16, 13'd16, 1'b0, 1'b0);
        1: s = settings_of(1'b1, CORNER_TR, 24'hffffff, 8'd255, 13'd4096, 13'd4096, 1'b1, 1'b1);
        2: s = settings_of(1'b0, CORNER_BR, 24'($urandom), 8'd128, 13'd320, 13'd240, 1'b0, 1'b0);
        3: s = settings_of(1'b1, CORNER_BL, 24'($urandom), 8'd51, 13'h1fff, 13'h1fff, 1'b0, 1'b1);
        4: s = settings_of(1'b1, CORNER_BR, 24'($urandom), 8'd204, 13'd8, 13'd5, 1'b0, 1'b0);
        5: s = settings_of(1'b1, CORNER_TL, 24'($urandom), 8'd255, 13'd9, 13'd12, 1'b1, 1'b0);
        default: s = random_settings();
      endcase
      load_settings(s);
      set_flow(flow_t'(phase % 4));
      repeat (100) send_item(random_item());
    end
  endtask

  task automatic test_back_pressure();
    load_settings(random_settings());
    set_flow(FLOW_FREE);
    hold_request <= 1'b1;
    repeat (60) send_item(random_item());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", 24'h000000, out_data.pixel_out);
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (out_data.pixel_out !== oldest_pixel.pixel_out)
          report_mismatch("pixel_out", oldest_pixel.pixel_out, out_data.pixel_out);
        if (out_data.gear_high !== oldest_pixel.gear_high)
          report_mismatch("gear_high", 24'(oldest_pixel.gear_high), 24'(out_data.gear_high));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gear_indicator_overlay_blend_unit test failed");
      $finish;
    end
  end

  initial begin
    settings = settings_of(1'b1, CORNER_BR, 24'h00ff00, 8'd204, 13'd320, 13'd240, 1'b0, 1'b0);
    gear_flag = 1'b0;
    prev_button = 1'b0;
    flash_timer = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_glyph_orientation();
    test_random_settings();
    test_back_pressure();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gear_indicator_overlay_blend_unit test passed");
    end else begin
      $display("gear_indicator_overlay_blend_unit test failed");
    end
    $finish;
  end

endmodule
